// ===== src/frame_check_route_segment_unit_macros.svh =====
// Assertion macros shared by the frame check and route segment unit.
`ifndef FRAME_CHECK_ROUTE_SEGMENT_UNIT_MACROS_SVH
`define FRAME_CHECK_ROUTE_SEGMENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FCRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FCRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fcrs_pkg.sv =====
// Shared types, constants and helpers of the frame check and route segment unit.
`timescale 1ns / 1ps
package fcrs_pkg;

   localparam int MAX_PAYLOAD_DEF = 64;
   localparam int SEGMENT_CHARS   = 7;
   localparam int NUM_DESTS       = 5;
   localparam int CHECK_MOD       = 16;
   localparam int CHECK_W         = $clog2(CHECK_MOD);

   localparam int DEST_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int CLEN_W    = 3;
   localparam int CHARS_W   = SEGMENT_CHARS * 8;
   localparam int COUNT_W   = 32;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PAD     = 8'h3F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] DEST_LO      = CHAR_ZERO + 8'(1);
   localparam logic [7:0] DEST_HI      = CHAR_ZERO + 8'(NUM_DESTS);

   typedef enum logic [STATUS_W-1:0] {
      ST_ROUTED   = 2'd0,
      ST_CHECK    = 2'd1,
      ST_DROP     = 2'd2,
      ST_OVERFLOW = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic             start;
      frame_status_type status;
      logic [DEST_W-1:0] dest;
   } line_cmd_type;

   typedef logic [SEGMENT_CHARS-1:0][7:0] chunk_type;

   // {valid, value} of a hex digit character
   function automatic logic [CHECK_W:0] hex_decode(input logic [7:0] c);
      logic [CHECK_W:0] r;
      r = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, CHECK_W'(c - CHAR_ZERO)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         r = {1'b1, CHECK_W'(c - CHAR_UPPER_A + 8'd10)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         r = {1'b1, CHECK_W'(c - CHAR_LOWER_A + 8'd10)};
      end
      return r;
   endfunction

endpackage

// ===== src/frame_check_route_segment_unit.sv =====
// Top level of the frame check and route segment unit.
//
// The req channel takes one character per transfer. Characters other than newline are
// written into the line store until it is full; req_ready stays high while a line fills.
// A newline closes the line: the line is judged (check digit, destination, overflow),
// and req_ready drops while the store is read back one character per cycle unless stalled.
// Each result on the rsp channel is one chunk of up to seven payload characters.
// The characters of a chunk are read through the registered store read port before the
// chunk is sent; the drain moves on to the next chunk once the output register takes it.
// A line with an empty payload, or a dropped line, gives one result.
// The last result of a line sits in the output register while the next line fills.
// When the receiver stalls, the result holds and the drain waits; nothing is lost.
// Synchronous reset clears the line length, the frame, reject and byte counters and the
// output valid; the line store needs no clearing, as only entries of the current line
// are ever read.
`timescale 1ns / 1ps
module frame_check_route_segment_unit import fcrs_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_char,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DEST_W-1:0]   rsp_out_dest,
   output logic [STATUS_W-1:0] rsp_frame_status,
   output logic [CHARS_W-1:0]  rsp_chunk_chars,
   output logic [CLEN_W-1:0]   rsp_chunk_len,
   output logic                rsp_chunk_last,
   output logic [COUNT_W-1:0]  rsp_frames_total,
   output logic [COUNT_W-1:0]  rsp_frames_rejected,
   output logic [COUNT_W-1:0]  rsp_dest_bytes
);

   localparam int DEPTH = MAX_PAYLOAD + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);

   logic               wr_en, rd_en, line_done;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [7:0]         wr_data, rd_data;
   line_cmd_type       cmd;
   logic [LW-1:0]      plen;
   logic [COUNT_W-1:0] frames_total, frames_rejected;

   fcrs_framer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_framer (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .line_done       (line_done),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .cmd             (cmd),
      .plen            (plen),
      .frames_total    (frames_total),
      .frames_rejected (frames_rejected)
   );

   fcrs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fcrs_drain #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_drain (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .plen                (plen),
      .frames_total        (frames_total),
      .frames_rejected     (frames_rejected),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data),
      .line_done           (line_done),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_dest        (rsp_out_dest),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_chunk_chars     (rsp_chunk_chars),
      .rsp_chunk_len       (rsp_chunk_len),
      .rsp_chunk_last      (rsp_chunk_last),
      .rsp_frames_total    (rsp_frames_total),
      .rsp_frames_rejected (rsp_frames_rejected),
      .rsp_dest_bytes      (rsp_dest_bytes)
   );

endmodule

// ===== src/fcrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fcrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 66
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fcrs_framer.sv =====
// Line framer: stores characters, judges the line at newline, keeps frame counters.
`timescale 1ns / 1ps
module fcrs_framer import fcrs_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_in_char,
   input  logic                                 line_done,
   output logic                                 wr_en,
   output logic [$clog2(MAX_PAYLOAD+2)-1:0]     wr_addr,
   output logic [7:0]                           wr_data,
   output line_cmd_type                         cmd,
   output logic [$clog2(MAX_PAYLOAD+3)-1:0]     plen,
   output logic [COUNT_W-1:0]                   frames_total,
   output logic [COUNT_W-1:0]                   frames_rejected
);

   localparam int DEPTH = MAX_PAYLOAD + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);

   logic [LW-1:0]      len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [7:0]         first_ff, first_in, last_ff, last_in;
   logic               busy_ff, busy_in;
   logic [COUNT_W-1:0] total_ff, total_in, reject_ff, reject_in;
   line_cmd_type       cmd_ff, cmd_in;
   logic [LW-1:0]      plen_ff, plen_in;

   logic               accept, is_nl, store;
   logic [CHECK_W:0]   hex;
   logic [LW-1:0]      plen_raw;
   frame_status_type   j_status;
   logic [DEST_W-1:0]  j_dest;
   logic [LW-1:0]      j_plen;
   logic               j_reject;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign is_nl     = (req_in_char == CHAR_NEWLINE);
   assign store     = accept && !is_nl && (len_ff < LW'(DEPTH));
   assign hex       = hex_decode(last_ff);
   assign plen_raw  = len_ff - LW'(2);

   always_comb begin
      j_status = ST_DROP;
      j_dest   = '0;
      j_plen   = plen_raw;
      j_reject = 1'b0;
      if (ovf_ff) begin
         j_status = ST_OVERFLOW;
         j_plen   = LW'(MAX_PAYLOAD);
         j_reject = 1'b1;
      end else if (len_ff < LW'(2)) begin
         j_status = ST_CHECK;
         j_plen   = '0;
         j_reject = 1'b1;
      end else if (!hex[CHECK_W] || plen_raw[CHECK_W-1:0] != hex[CHECK_W-1:0]) begin
         j_status = ST_CHECK;
         j_reject = 1'b1;
      end else if (first_ff >= DEST_LO && first_ff <= DEST_HI) begin
         j_status = ST_ROUTED;
         j_dest   = DEST_W'(first_ff - CHAR_ZERO);
      end
   end

   always_comb begin
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      busy_in   = busy_ff;
      total_in  = total_ff;
      reject_in = reject_ff;
      cmd_in    = cmd_ff;
      plen_in   = plen_ff;
      cmd_in.start = 1'b0;
      if (line_done) begin
         busy_in = 1'b0;
      end
      if (store) begin
         if (len_ff == '0) begin
            first_in = req_in_char;
         end
         last_in = req_in_char;
         len_in  = len_ff + LW'(1);
      end else if (accept && !is_nl) begin
         ovf_in = 1'b1;
      end
      if (accept && is_nl) begin
         busy_in       = 1'b1;
         total_in      = total_ff + COUNT_W'(1);
         reject_in     = reject_ff + COUNT_W'(j_reject);
         len_in        = '0;
         ovf_in        = 1'b0;
         cmd_in.start  = 1'b1;
         cmd_in.status = j_status;
         cmd_in.dest   = j_dest;
         plen_in       = j_plen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         total_ff     <= '0;
         reject_ff    <= '0;
         cmd_ff.start <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         total_ff     <= total_in;
         reject_ff    <= reject_in;
         cmd_ff.start <= cmd_in.start;
      end
      first_ff      <= first_in;
      last_ff       <= last_in;
      cmd_ff.status <= cmd_in.status;
      cmd_ff.dest   <= cmd_in.dest;
      plen_ff       <= plen_in;
   end

   assign wr_en           = store;
   assign wr_addr         = AW'(len_ff);
   assign wr_data         = req_in_char;
   assign cmd             = cmd_ff;
   assign plen            = plen_ff;
   assign frames_total    = total_ff;
   assign frames_rejected = reject_ff;

endmodule

// ===== src/fcrs_drain.sv =====
// Drain sequencer: reads the line store, builds chunks, keeps byte counters, drives results.
`timescale 1ns / 1ps
`include "frame_check_route_segment_unit_macros.svh"
module fcrs_drain import fcrs_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  line_cmd_type                         cmd,
   input  logic [$clog2(MAX_PAYLOAD+3)-1:0]     plen,
   input  logic [COUNT_W-1:0]                   frames_total,
   input  logic [COUNT_W-1:0]                   frames_rejected,
   output logic                                 rd_en,
   output logic [$clog2(MAX_PAYLOAD+2)-1:0]     rd_addr,
   input  logic [7:0]                           rd_data,
   output logic                                 line_done,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [DEST_W-1:0]                    rsp_out_dest,
   output logic [STATUS_W-1:0]                  rsp_frame_status,
   output logic [CHARS_W-1:0]                   rsp_chunk_chars,
   output logic [CLEN_W-1:0]                    rsp_chunk_len,
   output logic                                 rsp_chunk_last,
   output logic [COUNT_W-1:0]                   rsp_frames_total,
   output logic [COUNT_W-1:0]                   rsp_frames_rejected,
   output logic [COUNT_W-1:0]                   rsp_dest_bytes
);

   localparam int DEPTH = MAX_PAYLOAD + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(SEGMENT_CHARS + 1);
   localparam int IW    = $clog2(SEGMENT_CHARS);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   frame_status_type   status_ff, status_in;
   logic [DEST_W-1:0]  dest_ff, dest_in;
   logic [LW-1:0]      plen_ff, plen_in, pos_ff, pos_in;
   logic [CW-1:0]      n_ff, n_in, issue_ff, issue_in;
   logic               pend_ff, pend_in;
   chunk_type          chunk_ff, chunk_in;
   logic [COUNT_W-1:0] counters_ff [NUM_DESTS+1];
   logic [COUNT_W-1:0] counters_in [NUM_DESTS+1];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DEST_W-1:0]  rsp_dest_ff, rsp_dest_in;
   frame_status_type   rsp_status_ff, rsp_status_in;
   chunk_type          rsp_chars_ff, rsp_chars_in;
   logic [CLEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0] rsp_total_ff, rsp_total_in, rsp_rej_ff, rsp_rej_in;
   logic [COUNT_W-1:0] rsp_bytes_ff, rsp_bytes_in;

   frame_status_type   init_status;
   logic [LW-1:0]      init_plen, init_pos, init_rem;
   logic [CW-1:0]      init_n;
   logic [7:0]         init_fill;
   logic [LW-1:0]      pos_sum;
   logic               last_w, out_free;
   logic [COUNT_W-1:0] add_w, cnt_new;
   logic [CW-1:0]      cap_w;

   assign pos_sum     = pos_ff + LW'(n_ff);
   assign init_status = (state_ff == S_IDLE) ? cmd.status : status_ff;
   assign init_plen   = (state_ff == S_IDLE) ? plen : plen_ff;
   assign init_pos    = (state_ff == S_IDLE) ? '0 : pos_sum;
   assign init_rem    = init_plen - init_pos;

   always_comb begin
      if (init_status == ST_DROP) begin
         init_n = '0;
      end else if (init_rem > LW'(SEGMENT_CHARS)) begin
         init_n = CW'(SEGMENT_CHARS);
      end else begin
         init_n = CW'(init_rem);
      end
      if (init_n == '0 || init_status != ST_ROUTED) begin
         init_fill = 8'h00;
      end else begin
         init_fill = CHAR_PAD;
      end
   end

   assign last_w   = (status_ff == ST_DROP) || (pos_sum >= plen_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cap_w    = issue_ff - CW'(1);
   assign cnt_new  = counters_ff[dest_ff] + add_w;
   assign rd_en    = (state_ff == S_READ) && (issue_ff < n_ff);
   assign rd_addr  = AW'(pos_ff + LW'(issue_ff) + LW'(1));

   always_comb begin
      case (status_ff)
         ST_ROUTED: add_w = (n_ff == '0) ? '0 : COUNT_W'(SEGMENT_CHARS + 2);
         ST_DROP:   add_w = '0;
         default:   add_w = COUNT_W'(n_ff) + COUNT_W'(last_w);
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      dest_in       = dest_ff;
      plen_in       = plen_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      chunk_in      = chunk_ff;
      counters_in   = counters_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_dest_in   = rsp_dest_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chars_in  = rsp_chars_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      line_done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               status_in = cmd.status;
               dest_in   = cmd.dest;
               plen_in   = plen;
               pos_in    = '0;
               n_in      = init_n;
               issue_in  = '0;
               chunk_in  = {SEGMENT_CHARS{init_fill}};
               state_in  = S_READ;
            end
         end
         S_READ: begin
            if (pend_ff) begin
               chunk_in[cap_w[IW-1:0]] = rd_data;
            end
            if (rd_en) begin
               issue_in = issue_ff + CW'(1);
               pend_in  = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_dest_in           = dest_ff;
               rsp_status_in         = status_ff;
               rsp_chars_in          = chunk_ff;
               rsp_len_in            = CLEN_W'(n_ff);
               rsp_last_in           = last_w;
               rsp_total_in          = frames_total;
               rsp_rej_in            = frames_rejected;
               rsp_bytes_in          = cnt_new;
               counters_in[dest_ff]  = cnt_new;
               if (last_w) begin
                  line_done = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  pos_in   = pos_sum;
                  n_in     = init_n;
                  issue_in = '0;
                  chunk_in = {SEGMENT_CHARS{init_fill}};
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= NUM_DESTS; i++) begin
            counters_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         counters_ff  <= counters_in;
      end
      status_ff     <= status_in;
      dest_ff       <= dest_in;
      plen_ff       <= plen_in;
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      issue_ff      <= issue_in;
      chunk_ff      <= chunk_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chars_ff  <= rsp_chars_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_dest        = rsp_dest_ff;
   assign rsp_frame_status    = rsp_status_ff;
   assign rsp_chunk_chars     = rsp_chars_ff;
   assign rsp_chunk_len       = rsp_len_ff;
   assign rsp_chunk_last      = rsp_last_ff;
   assign rsp_frames_total    = rsp_total_ff;
   assign rsp_frames_rejected = rsp_rej_ff;
   assign rsp_dest_bytes      = rsp_bytes_ff;

   `FCRS_ASSERT_NOW(a_start_idle, cmd.start, state_ff == S_IDLE, "line started while draining")
   `FCRS_ASSERT_NOW(a_read_in_payload, rd_en, (pos_ff + LW'(issue_ff)) < plen_ff, "read past payload")
   `FCRS_ASSERT_NOW(a_capture_index, pend_ff, issue_ff != '0, "capture without issued read")
   `FCRS_ASSERT_NEXT(a_done_idle, line_done, state_ff == S_IDLE && rsp_chunk_last, "line end not last")

endmodule

// ===== tb/frame_check_route_segment_unit_test.sv =====
// Testbench for the line framing, check and routing unit with a built-in line predictor.
`timescale 1ns / 1ps
module frame_check_route_segment_unit_test;
   import fcrs_pkg::*;

   localparam int STORE_DEPTH  = MAX_PAYLOAD_DEF + 2;
   localparam int RANDOM_CHARS = 40;
   localparam int MIN_LINES    = 3;
   localparam int PHASE_CHARS  = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [DEST_W-1:0]  dest;
      frame_status_type   status;
      logic [CHARS_W-1:0] chars;
      logic [CLEN_W-1:0]  len;
      logic               last;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] rejected;
      logic [COUNT_W-1:0] bytes;
   } chunk_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_in_char = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DEST_W-1:0]   rsp_out_dest;
   logic [STATUS_W-1:0] rsp_frame_status;
   logic [CHARS_W-1:0]  rsp_chunk_chars;
   logic [CLEN_W-1:0]   rsp_chunk_len;
   logic                rsp_chunk_last;
   logic [COUNT_W-1:0]  rsp_frames_total;
   logic [COUNT_W-1:0]  rsp_frames_rejected;
   logic [COUNT_W-1:0]  rsp_dest_bytes;

   logic [7:0]         char_queue [$];
   chunk_result_type   expected_chunks [$];
   logic [7:0]         line_buf [0:STORE_DEPTH-1];
   int unsigned        line_fill = 0;
   bit                 line_overflow = 1'b0;
   logic [COUNT_W-1:0] lines_seen = '0;
   logic [COUNT_W-1:0] lines_rejected = '0;
   logic [COUNT_W-1:0] stream_bytes [0:NUM_DESTS];

   int unsigned chars_total = 0;
   int unsigned chars_accepted = 0;
   int unsigned hold_at_char = 0;
   int unsigned hold_cycles_left = 0;
   bit          hold_started = 1'b0;
   int unsigned chunks_checked = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   frame_check_route_segment_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_char         (req_in_char),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_dest        (rsp_out_dest),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_chunk_chars     (rsp_chunk_chars),
      .rsp_chunk_len       (rsp_chunk_len),
      .rsp_chunk_last      (rsp_chunk_last),
      .rsp_frames_total    (rsp_frames_total),
      .rsp_frames_rejected (rsp_frames_rejected),
      .rsp_dest_bytes      (rsp_dest_bytes)
   );

   always #5 clock = ~clock;

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return int'(c - CHAR_LOWER_A) + 10;
      return -1;
   endfunction

   function automatic logic [CHARS_W-1:0] gather_chars(input int unsigned start,
                                                       input int unsigned n,
                                                       input logic [7:0] pad);
      logic [CHARS_W-1:0] v;
      v = '0;
      for (int i = 0; i < SEGMENT_CHARS; i++) begin
         if (i < n && start + i < STORE_DEPTH) v[8*i +: 8] = line_buf[start + i];
         else v[8*i +: 8] = pad;
      end
      return v;
   endfunction

   function automatic void push_chunk(input logic [DEST_W-1:0] dest,
                                      input frame_status_type status,
                                      input logic [CHARS_W-1:0] chars,
                                      input int unsigned n, input bit last,
                                      input logic [COUNT_W-1:0] bytes);
      chunk_result_type r;
      r.dest     = dest;
      r.status   = status;
      r.chars    = chars;
      r.len      = CLEN_W'(n);
      r.last     = last;
      r.total    = lines_seen;
      r.rejected = lines_rejected;
      r.bytes    = bytes;
      expected_chunks.push_back(r);
   endfunction

   function automatic void predict_reject(input frame_status_type status,
                                          input int unsigned plen);
      int unsigned pos;
      int unsigned n;
      bit last;
      pos = 0;
      do begin
         n = plen - pos;
         if (n > SEGMENT_CHARS) n = SEGMENT_CHARS;
         last = (pos + n >= plen);
         stream_bytes[0] += n + last;
         push_chunk('0, status, gather_chars(1 + pos, n, 8'h00), n, last, stream_bytes[0]);
         pos += n;
      end while (pos < plen);
   endfunction

   function automatic void predict_routed(input int unsigned dest, input int unsigned plen);
      int unsigned pos;
      int unsigned n;
      if (plen == 0) begin
         push_chunk(DEST_W'(dest), ST_ROUTED, '0, 0, 1'b1, stream_bytes[dest]);
         return;
      end
      pos = 0;
      while (pos < plen) begin
         n = plen - pos;
         if (n > SEGMENT_CHARS) n = SEGMENT_CHARS;
         stream_bytes[dest] += SEGMENT_CHARS + 2;
         push_chunk(DEST_W'(dest), ST_ROUTED, gather_chars(1 + pos, n, CHAR_PAD), n,
                    pos + n >= plen, stream_bytes[dest]);
         pos += n;
      end
   endfunction

   function automatic void predict_char(input logic [7:0] c);
      int unsigned plen;
      int hv;
      if (c != CHAR_NEWLINE) begin
         if (line_fill < STORE_DEPTH) begin
            line_buf[line_fill] = c;
            line_fill++;
         end else begin
            line_overflow = 1'b1;
         end
         return;
      end
      lines_seen++;
      if (line_overflow) begin
         lines_rejected++;
         predict_reject(ST_OVERFLOW, MAX_PAYLOAD_DEF);
      end else if (line_fill < 2) begin
         lines_rejected++;
         predict_reject(ST_CHECK, 0);
      end else begin
         plen = line_fill - 2;
         hv = hex_digit_value(line_buf[line_fill - 1]);
         if (hv < 0 || plen % CHECK_MOD != hv) begin
            lines_rejected++;
            predict_reject(ST_CHECK, plen);
         end else if (line_buf[0] >= DEST_LO && line_buf[0] <= DEST_HI) begin
            predict_routed(line_buf[0] - CHAR_ZERO, plen);
         end else begin
            push_chunk('0, ST_DROP, '0, 0, 1'b1, stream_bytes[0]);
         end
      end
      line_fill = 0;
      line_overflow = 1'b0;
   endfunction

   function automatic void check_chunk();
      chunk_result_type got;
      chunk_result_type want;
      got.dest     = rsp_out_dest;
      got.status   = frame_status_type'(rsp_frame_status);
      got.chars    = rsp_chunk_chars;
      got.len      = rsp_chunk_len;
      got.last     = rsp_chunk_last;
      got.total    = rsp_frames_total;
      got.rejected = rsp_frames_rejected;
      got.bytes    = rsp_dest_bytes;
      chunks_checked++;
      if (expected_chunks.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("unexpected chunk: dest %0d status %0d chars %h len %0d", got.dest,
                     got.status, got.chars, got.len);
         return;
      end
      want = expected_chunks.pop_front();
      if (got !== want) begin
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("chunk %0d mismatch (expected/actual): dest %0d/%0d status %0d/%0d",
                     chunks_checked, want.dest, got.dest, want.status, got.status);
            $display("   chars %h/%h len %0d/%0d last %0d/%0d",
                     want.chars, got.chars, want.len, got.len, want.last, got.last);
            $display("   total %0d/%0d rejected %0d/%0d bytes %0d/%0d",
                     want.total, got.total, want.rejected, got.rejected,
                     want.bytes, got.bytes);
         end
      end
   endfunction

   function automatic idle_mode_type current_idle_mode();
      return idle_mode_type'((chars_accepted / PHASE_CHARS) % 4);
   endfunction

   function automatic bit sender_pauses();
      case (current_idle_mode())
         IDLE_SENDER: return $urandom_range(0, 99) < 81;
         IDLE_BOTH:   return $urandom_range(0, 99) < 11;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (current_idle_mode())
         IDLE_RECEIVER: return $urandom_range(0, 99) < 81;
         IDLE_BOTH:     return $urandom_range(0, 99) < 11;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] line_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_NEWLINE);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
      if (v < 10) return 8'(CHAR_ZERO + v);
      if (upper) return 8'(CHAR_UPPER_A + v - 10);
      return 8'(CHAR_LOWER_A + v - 10);
   endfunction

   function automatic logic [7:0] pick_dest();
      if ($urandom_range(0, 9) < 8) return 8'(DEST_LO + $urandom_range(0, NUM_DESTS - 1));
      return line_byte();
   endfunction

   function automatic void queue_text(input string s);
      for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
   endfunction

   function automatic void queue_line(input logic [7:0] dest_char, input int unsigned plen,
                                      input logic [7:0] check_char);
      char_queue.push_back(dest_char);
      repeat (plen) char_queue.push_back(line_byte());
      char_queue.push_back(check_char);
      char_queue.push_back(CHAR_NEWLINE);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_cycles_left <= 0;
         hold_started <= 1'b0;
      end else if (!hold_started && chars_accepted >= hold_at_char) begin
         hold_cycles_left <= HOLD_CYCLES;
         hold_started <= 1'b1;
      end else if (hold_cycles_left != 0) begin
         hold_cycles_left <= hold_cycles_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_in_char <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_char(req_in_char);
            chars_accepted <= chars_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (char_queue.size() != 0 && (hold_cycles_left != 0 || !sender_pauses())) begin
               req_valid <= 1'b1;
               req_in_char <= char_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_chunk();
         rsp_ready <= (hold_cycles_left == 0) && !receiver_stalls();
      end
   end

   initial begin
      string       non_hex_edges;
      int unsigned kind;
      int unsigned plen;
      int unsigned random_start;
      int unsigned random_lines;
      non_hex_edges = "/:@G`g";
      for (int i = 0; i <= NUM_DESTS; i++) stream_bytes[i] = '0;
      for (int i = 0; i < STORE_DEPTH; i++) line_buf[i] = '0;

      queue_text("\n");
      queue_text("1\n");
      queue_text("10\n");
      queue_text("9\n");
      queue_text("1x\n");
      queue_text("5abcdefg7\n");
      queue_text("2segment+8\n");
      queue_text("0drop4\n");
      queue_text("6late4\n");
      queue_text("3abZ\n");
      queue_text("4abc2\n");
      queue_text("1lowercase!a\n");
      queue_text("2UPPERCASE!!B\n");
      char_queue.push_back("3");
      char_queue.push_back(8'h00);
      char_queue.push_back(8'hFF);
      char_queue.push_back(8'h80);
      char_queue.push_back(8'h7F);
      queue_text("4\n");
      for (int i = 0; i < non_hex_edges.len(); i++) queue_line("1", 2, non_hex_edges[i]);
      queue_line("5", 15, "F");
      queue_line("1", 15, "f");
      queue_line("4", 9, "9");
      queue_line("3", 16, "0");
      queue_line("4", MAX_PAYLOAD_DEF, "0");
      queue_line("1", MAX_PAYLOAD_DEF + 1, "1");
      hold_at_char = char_queue.size() / 2;

      random_start = char_queue.size();
      random_lines = 0;
      while (char_queue.size() - random_start < RANDOM_CHARS || random_lines < MIN_LINES) begin
         kind = $urandom_range(0, 99);
         plen = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 14)
                                           : $urandom_range(15, MAX_PAYLOAD_DEF);
         if (kind < 65) begin
            queue_line(pick_dest(), plen, hex_char(plen % CHECK_MOD, $urandom_range(0, 1)));
         end else if (kind < 80) begin
            if ($urandom_range(0, 1))
               queue_line(pick_dest(), plen, line_byte());
            else
               queue_line(pick_dest(), plen,
                          hex_char((plen + $urandom_range(1, 15)) % CHECK_MOD,
                                   $urandom_range(0, 1)));
         end else if (kind < 85) begin
            queue_line(pick_dest(), $urandom_range(MAX_PAYLOAD_DEF + 1, MAX_PAYLOAD_DEF + 16),
                       line_byte());
         end else begin
            repeat ($urandom_range(0, 2)) char_queue.push_back(line_byte());
            char_queue.push_back(CHAR_NEWLINE);
         end
         random_lines++;
      end
      chars_total = char_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (chars_accepted != chars_total) @(negedge clock);
      while (expected_chunks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d characters in %0d lines, %0d result chunks checked,",
               chars_total, lines_seen, chunks_checked);
      $display("across idle, stall and output hold-off phases; %0d mismatches.", failures);
      if (failures == 0 && expected_chunks.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
